/* rtl/celoss_pkg.sv */
// Shared types and constants of the clipped cross-entropy loss block.
package celoss_pkg;

    localparam int ONE_Q15   = 32768;
    localparam int LN2_Q16   = 45426;
    localparam int GRAD_W    = 17;
    localparam int TERM_W    = 20;
    localparam int CONTRIB_W = 21;
    localparam int SUM_W     = 48;
    localparam int MEAN_W    = 32;
    localparam int ROWS_W    = 17;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        REG_EPSILON = 2'd0,
        REG_CLASSES = 2'd1,
        REG_ROWS    = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_DIV,
        BE_EMIT
    } t_be_state;

    // One classified element travelling from the front to the back.
    typedef struct packed {
        logic signed [GRAD_W-1:0]    grad;
        logic        [CONTRIB_W-1:0] contrib;
        logic                        last;
        logic        [ROWS_W-1:0]    rows;
    } t_elem;

endpackage

/* rtl/celoss_front.sv */
// Front part: accepts words, tracks row and batch position, computes the loss term.
module celoss_front
    import celoss_pkg::*;
#(
    parameter int MAX_CLASSES    = 1024,
    parameter int MAX_ROWS       = 4096,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_prediction,
    input  logic [15:0] i_target,
    input  logic [13:0] i_eps,
    input  logic [10:0] i_classes,
    input  logic [12:0] i_rows,
    output logic        o_push,
    output t_elem       o_elem,
    input  logic        i_full
);

    localparam int CCW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CLW = $clog2(MAX_CLASSES + 1);
    localparam int RCW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RLW = $clog2(MAX_ROWS + 1);
    localparam int LTB = LOG_TABLE_BITS;
    localparam int TN  = 1 << LOG_TABLE_BITS;

    // ln(1 + i/TN) in Q16, rounded to nearest.
    logic [15:0] w_ln [TN];
    for (genvar gi = 0; gi < TN; gi++) begin : g_tbl
        localparam real LnVal = $ln(1.0 + real'(gi) / real'(TN)) * 65536.0;
        assign w_ln[gi] = 16'($rtoi(LnVal + 0.5));
    end

    logic [CCW-1:0] r_cls_cnt;
    logic [RCW-1:0] r_row_cnt;

    logic              r_v1, r_v2;
    logic [15:0]       r1_pred, r1_tgt, r2_tgt;
    logic              r1_last, r2_last;
    logic [ROWS_W-1:0] r1_rows, r2_rows;
    logic [TERM_W-1:0] r2_term;
    logic signed [GRAD_W-1:0] r2_grad;

    logic          w_adv2, w_adv1, w_accept;
    logic [10:0]   w_cls_nz;
    logic [12:0]   w_rows_nz;
    logic [CLW-1:0] w_cls, w_cls_p1;
    logic [RLW-1:0] w_rows, w_row_p1;
    logic          w_row_end, w_batch_end;
    logic [15:0]   w_pred, w_tgt;

    assign w_adv2   = !r_v2 || !i_full;
    assign w_adv1   = !r_v1 || w_adv2;
    assign o_stall  = !w_adv1;
    assign w_accept = i_valid && w_adv1;

    assign w_pred = (i_prediction > 16'(ONE_Q15)) ? 16'(ONE_Q15) : i_prediction;
    assign w_tgt  = (i_target > 16'(ONE_Q15)) ? 16'(ONE_Q15) : i_target;

    always_comb begin
        w_cls_nz  = (i_classes == '0) ? 11'd1 : i_classes;
        w_rows_nz = (i_rows == '0) ? 13'd1 : i_rows;
        w_cls  = (32'(w_cls_nz) > MAX_CLASSES) ? CLW'(MAX_CLASSES) : CLW'(w_cls_nz);
        w_rows = (32'(w_rows_nz) > MAX_ROWS) ? RLW'(MAX_ROWS) : RLW'(w_rows_nz);
        w_cls_p1 = CLW'(r_cls_cnt) + CLW'(1);
        w_row_p1 = RLW'(r_row_cnt) + RLW'(1);
        w_row_end   = w_cls_p1 >= w_cls;
        w_batch_end = w_row_end && (w_row_p1 >= w_rows);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_accept) begin
            if (w_row_end) begin
                r_cls_cnt <= '0;
                r_row_cnt <= w_batch_end ? '0 : RCW'(w_row_p1);
            end else begin
                r_cls_cnt <= CCW'(w_cls_p1);
            end
        end
    end

    // Clip, find the leading one and look up the fractional log.
    logic [15:0]     w_eps, w_hi, w_clip;
    logic [14:0]     w_c, w_norm;
    logic [3:0]      w_k;
    logic [13+LTB:0] w_frac;
    logic [LTB-1:0]  w_idx;
    logic [TERM_W-1:0] w_whole, w_term;

    always_comb begin
        w_eps  = (i_eps == '0) ? 16'd1 : 16'(i_eps);
        w_hi   = 16'(ONE_Q15) - w_eps;
        w_clip = (r1_pred < w_eps) ? w_eps : r1_pred;
        w_clip = (w_clip > w_hi) ? w_hi : w_clip;
        w_c    = w_clip[14:0];
        w_k    = '0;
        for (int i = 0; i < 15; i++) begin
            if (w_c[i]) begin
                w_k = 4'(i);
            end
        end
        w_norm  = 15'(w_c << (4'd14 - w_k));
        w_frac  = {w_norm[13:0], LTB'(0)};
        w_idx   = w_frac[13+LTB -: LTB];
        w_whole = TERM_W'(4'd15 - w_k) * TERM_W'(LN2_Q16);
        w_term  = (w_whole > TERM_W'(w_ln[w_idx])) ? w_whole - TERM_W'(w_ln[w_idx]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_pred <= w_pred;
            r1_tgt  <= w_tgt;
            r1_last <= w_batch_end;
            r1_rows <= ROWS_W'(w_rows);
        end
        if (w_adv2 && r_v1) begin
            r2_term <= w_term;
            r2_tgt  <= r1_tgt;
            r2_last <= r1_last;
            r2_rows <= r1_rows;
            r2_grad <= GRAD_W'({1'b0, r1_pred}) - GRAD_W'({1'b0, r1_tgt});
        end
    end

    logic [35:0] w_prod;
    assign w_prod = 36'(r2_tgt) * 36'(r2_term) + 36'(1 << 14);

    assign o_push         = r_v2 && !i_full;
    assign o_elem.grad    = r2_grad;
    assign o_elem.contrib = CONTRIB_W'(w_prod >> 15);
    assign o_elem.last    = r2_last;
    assign o_elem.rows    = r2_rows;

endmodule

/* rtl/celoss_queue.sv */
// Short queue that decouples the front from the back.
module celoss_queue
    import celoss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_elem i_elem,
    output logic  o_full,
    output logic  o_valid,
    output t_elem o_elem,
    input  logic  i_pop
);

    localparam int DEPTH = 4;

    t_elem      r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_count;
    logic       w_do_push, w_do_pop;

    assign o_full    = r_count == 3'(DEPTH);
    assign o_valid   = r_count != '0;
    assign o_elem    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_count <= r_count + 3'(w_do_push) - 3'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_elem;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(DEPTH)) else $error("queue count overflow");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push && !w_do_pop |=> r_count == $past(r_count) + 3'd1)
        else $error("queue count did not grow");
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_pop && !w_do_push |=> r_count == $past(r_count) - 3'd1)
        else $error("queue count did not shrink");

endmodule

/* rtl/celoss_back.sv */
// Back part: accumulates the loss, divides by the row count and drives the result word.
module celoss_back
    import celoss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_elem                    i_q_elem,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [GRAD_W-1:0] o_gradient,
    output logic [MEAN_W-1:0]        o_mean_loss,
    output logic                     o_loss_valid,
    output logic                     o_last_element
);

    t_be_state r_state, n_state;
    logic [SUM_W-1:0]     r_sum, n_sum, r_num, n_num;
    logic [ROWS_W-1:0]    r_div, n_div, r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic signed [GRAD_W-1:0] r_grad, n_grad;
    logic                 r_ov, n_ov;
    logic signed [GRAD_W-1:0] n_og;
    logic [MEAN_W-1:0]    r_om, n_om;
    logic                 r_olast, n_olast;

    logic                 w_out_free;
    logic [SUM_W:0]       w_add;
    logic [SUM_W-1:0]     w_sum_sat;
    logic [ROWS_W:0]      w_trial;
    logic                 w_ge;

    assign w_out_free = !r_ov || !i_stall;
    assign w_add      = (SUM_W+1)'(r_sum) + (SUM_W+1)'(i_q_elem.contrib);
    assign w_sum_sat  = w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
    assign w_trial    = {r_rem, r_num[SUM_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_num   = r_num;
        n_div   = r_div;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_grad  = r_grad;
        n_ov    = r_ov && i_stall;
        n_og    = o_gradient;
        n_om    = r_om;
        n_olast = r_olast;
        o_q_pop = 1'b0;
        unique case (r_state)
            BE_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_elem.last) begin
                        n_sum   = '0;
                        n_num   = w_sum_sat;
                        n_div   = i_q_elem.rows;
                        n_rem   = '0;
                        n_cnt   = DIV_CNT_W'(SUM_W);
                        n_grad  = i_q_elem.grad;
                        n_state = BE_DIV;
                    end else begin
                        n_sum   = w_sum_sat;
                        n_ov    = 1'b1;
                        n_og    = i_q_elem.grad;
                        n_om    = '0;
                        n_olast = 1'b0;
                    end
                end
            end
            BE_DIV: begin
                n_rem = w_ge ? ROWS_W'(w_trial - {1'b0, r_div}) : ROWS_W'(w_trial);
                n_num = {r_num[SUM_W-2:0], w_ge};
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    n_state = BE_EMIT;
                end
            end
            BE_EMIT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_og    = r_grad;
                    n_om    = (|r_num[SUM_W-1:MEAN_W]) ? '1 : r_num[MEAN_W-1:0];
                    n_olast = 1'b1;
                    n_state = BE_IDLE;
                end
            end
            default: n_state = BE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BE_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_grad     <= n_grad;
        o_gradient <= n_og;
        r_om       <= n_om;
        r_olast    <= n_olast;
    end

    assign o_valid        = r_ov;
    assign o_mean_loss    = r_om;
    assign o_loss_valid   = r_olast;
    assign o_last_element = r_olast;

    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_loss_valid |-> o_mean_loss == '0)
        else $error("mean loss set off the batch end");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BE_DIV |-> r_cnt != '0) else $error("divider count underflow");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BE_DIV |=> r_state == BE_DIV || r_state == BE_EMIT)
        else $error("divider left early");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != BE_IDLE |-> !o_q_pop) else $error("pop while dividing");

endmodule

/* rtl/cross_entropy_loss_and_gradient.sv */
// Top level of the clipped cross-entropy loss and gradient block.
// Path: an ordinary word passes the two front registers, the queue and the output register;
// the last word of a batch also runs the bit-serial row divider over the 48-bit sum, then an emit step.
// Throughput: one word per cycle inside a batch while the output is not stalled and the queue has room;
// the divider holds the back once per batch while the front keeps filling the four-entry queue.
// Reset (synchronous, active low) clears the sum, the counters and the stage and output valid flags
// (not the loss-valid flag) and sets every configuration register to one.
module cross_entropy_loss_and_gradient
    import celoss_pkg::*;
#(
    parameter int MAX_CLASSES    = 1024,
    parameter int MAX_ROWS       = 4096,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [15:0]              i_prediction,
    input  logic [15:0]              i_target,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [GRAD_W-1:0] o_gradient,
    output logic [MEAN_W-1:0]        o_mean_loss,
    output logic                     o_loss_valid,
    output logic                     o_last_element
);

    // Configuration registers, one per 32-bit word address.
    logic [13:0] r_eps;
    logic [10:0] r_classes;
    logic [12:0] r_rows;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps     <= 14'd1;
            r_classes <= 11'd1;
            r_rows    <= 13'd1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_EPSILON: r_eps     <= pwdata[13:0];
                REG_CLASSES: r_classes <= pwdata[10:0];
                REG_ROWS:    r_rows    <= pwdata[12:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_EPSILON: prdata = 32'(r_eps);
            REG_CLASSES: prdata = 32'(r_classes);
            REG_ROWS:    prdata = 32'(r_rows);
            default:     prdata = '0;
        endcase
    end

    // The front classifies each word and computes its loss contribution; the
    // queue lets it keep running while the back is busy with a batch division.
    logic  w_push, w_full, w_q_valid, w_pop;
    t_elem w_push_elem, w_q_elem;

    celoss_front #(
        .MAX_CLASSES   (MAX_CLASSES),
        .MAX_ROWS      (MAX_ROWS),
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_prediction(i_prediction),
        .i_target    (i_target),
        .i_eps       (r_eps),
        .i_classes   (r_classes),
        .i_rows      (r_rows),
        .o_push      (w_push),
        .o_elem      (w_push_elem),
        .i_full      (w_full)
    );

    celoss_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_elem (w_push_elem),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_elem (w_q_elem),
        .i_pop  (w_pop)
    );

    // The back owns the running sum, the divider and the output register.
    celoss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_elem      (w_q_elem),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_gradient    (o_gradient),
        .o_mean_loss   (o_mean_loss),
        .o_loss_valid  (o_loss_valid),
        .o_last_element(o_last_element)
    );

endmodule
